@@ rtl/ffea_pkg.sv @@
// ----------------------------------------------------------------------------
// ffea_pkg
// Shared types and codes of the first-fit extent allocator.
// ----------------------------------------------------------------------------
package ffea_pkg;

  localparam int ADDR_W = 16;
  localparam int LEN_W  = 17;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [1:0]        opcode_t;
  typedef logic [1:0]        status_t;

  // Request opcodes; code 3 does nothing
  localparam opcode_t OP_ALLOC   = 2'd0;
  localparam opcode_t OP_FREE    = 2'd1;
  localparam opcode_t OP_REBUILD = 2'd2;

  // Response status codes
  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_NO_FIT  = 2'd1;
  localparam status_t ST_NO_SLOT = 2'd2;

  localparam addr_t HEAP_START_RESET = 16'h0801;
  localparam len_t  LEN_MAX          = 17'h1FFFF;

  typedef enum logic [2:0] {
    S_BOOT,
    S_IDLE,
    S_REBUILD,
    S_WALK,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

@@ rtl/first_fit_extent_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// first_fit_extent_allocator_unit
// First-fit allocator over a linked list of free extents kept in a
// descriptor memory.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the in_ stream: in_tuser carries the opcode (allocate,
//   free, rebuild), in_tdata the size and, for free, the extent address.
//   Every request yields exactly one response on the out_ stream carrying a
//   status and, on a successful allocate, the granted address.
//   heap_start is written through the cfg_ channel while no request is open, a rule
//   for the user that the block does not enforce; it only takes effect at the next rebuild request.
// Operation per request:
//   allocate : walks the list from the head, one list hop per cycle, visiting
//              up to DESCRIPTOR_SLOTS extents; each hop is a registered read of the
//              descriptor memory feeding the length compare.
//   free     : scans the valid bits from slot 0 up to the lowest unused slot
//              (up to DESCRIPTOR_SLOTS slots), one valid bit per cycle.
//   rebuild  : rewrites slot 0 and the list; empty opcode: goes straight to the response.
//   One request is in flight at a time; the next one is taken in the cycle
//   after the response is loaded, while that response may still wait.
// Reset: the boot state writes slot 0 with the 0x0801 heap extent; requests
//   and configuration writes are held off during that state.
// Stall: a response waits in the output register; if a second response is
//   ready before the first is taken, the block holds until out_tready.
// ----------------------------------------------------------------------------
module first_fit_extent_allocator_unit #(
  parameter int DESCRIPTOR_SLOTS = 32,
  parameter int SPACE_BYTES      = 65536
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // request stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [39:0]          in_tdata,   // [16:0] request_size, [32:17] free_address
  input  ffea_pkg::opcode_t    in_tuser,   // [1:0] opcode
  // response stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [23:0]          out_tdata,  // [1:0] status, [17:2] granted_address
  // configuration write
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  ffea_pkg::addr_t      cfg_data    // heap_start
);
  import ffea_pkg::*;

  localparam int IDX_W  = (DESCRIPTOR_SLOTS > 1) ? $clog2(DESCRIPTOR_SLOTS) : 1;
  localparam int LINK_W = $clog2(DESCRIPTOR_SLOTS + 1);
  localparam int WORD_W = ADDR_W + LEN_W + LINK_W;
  localparam int SPW    = $clog2(SPACE_BYTES + 1);
  localparam int CW     = (SPW > LEN_W) ? SPW : LEN_W;

  localparam logic [LINK_W-1:0] LIST_END  = LINK_W'(DESCRIPTOR_SLOTS);
  localparam logic [IDX_W-1:0]  LAST_SLOT = IDX_W'(DESCRIPTOR_SLOTS - 1);
  localparam logic [CW-1:0]     SPACE_C   = CW'(SPACE_BYTES);

  // descriptor memory: {link, length, start}
  logic [WORD_W-1:0] mem [DESCRIPTOR_SLOTS];
  logic [WORD_W-1:0] rdata_r;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;

  state_t                state_r, state_nxt;
  opcode_t               op_r;
  len_t                  size_r, size_nxt;
  addr_t                 faddr_r, faddr_nxt;
  addr_t                 heap_start_r;
  logic [LINK_W-1:0]     head_r, head_nxt;
  logic [DESCRIPTOR_SLOTS-1:0] valid_r, valid_nxt;
  logic [IDX_W-1:0]      cur_r, cur_nxt;
  logic [LINK_W-1:0]     prev_r, prev_nxt;
  addr_t                 prev_start_r, prev_start_nxt;
  len_t                  prev_len_r, prev_len_nxt;
  logic [IDX_W-1:0]      scan_r, scan_nxt;
  status_t               res_status_r, res_status_nxt;
  addr_t                 res_addr_r, res_addr_nxt;
  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  addr_t                 out_addr_r, out_addr_nxt;

  logic in_fire;
  logic out_free;

  // fields of the descriptor just read
  addr_t             r_start;
  len_t              r_len;
  logic [LINK_W-1:0] r_link;
  logic              fit;
  len_t              rem_len;
  logic              exact;
  logic              next_ok;
  logic              head_ok;

  // rebuild extent
  logic [CW-1:0]     span;
  logic              heap_in;
  len_t              init_len;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = (state_r != S_BOOT);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_addr_r, out_status_r};

  assign r_start = rdata_r[ADDR_W-1:0];
  assign r_len   = rdata_r[ADDR_W +: LEN_W];
  assign r_link  = rdata_r[WORD_W-1 -: LINK_W];
  assign fit     = (r_len >= size_r);
  assign rem_len = r_len - size_r;
  assign exact   = (rem_len == '0);
  assign next_ok = (r_link != LIST_END) && valid_r[r_link[IDX_W-1:0]];
  assign head_ok = (head_r != LIST_END) && valid_r[head_r[IDX_W-1:0]];

  assign span     = SPACE_C - CW'(heap_start_r);
  assign heap_in  = (CW'(heap_start_r) < SPACE_C);
  assign init_len = (span > CW'(LEN_MAX)) ? LEN_MAX : span[LEN_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_BOOT:    state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_tuser)
            OP_ALLOC:   state_nxt = ((head_r != LIST_END) && valid_r[head_r[IDX_W-1:0]])
                                    ? S_WALK : S_DONE;
            OP_FREE:    state_nxt = S_SCAN;
            OP_REBUILD: state_nxt = S_REBUILD;
            default:    state_nxt = S_DONE;
          endcase
        end
      end
      S_REBUILD: state_nxt = S_DONE;
      S_WALK: begin
        if (fit || !next_ok) begin
          state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        if (!valid_r[scan_r] || (scan_r == LAST_SLOT)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:   state_nxt = S_BOOT;
    endcase
  end

  // datapath and memory control
  always_comb begin
    size_nxt       = size_r;
    faddr_nxt      = faddr_r;
    head_nxt       = head_r;
    valid_nxt      = valid_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    prev_start_nxt = prev_start_r;
    prev_len_nxt   = prev_len_r;
    scan_nxt       = scan_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = {LIST_END, init_len, heap_start_r};
    rd_en          = 1'b0;
    rd_addr        = head_r[IDX_W-1:0];

    // drop the response once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r) inside
      S_BOOT, S_REBUILD: begin
        // rebuild the list as one extent in slot 0, or empty if heap_start is outside the space
        mem_we    = 1'b1;
        mem_waddr = '0;
        valid_nxt = heap_in ? DESCRIPTOR_SLOTS'(1) : '0;
        head_nxt  = heap_in ? '0 : LIST_END;
      end
      S_IDLE: begin
        if (in_fire) begin
          size_nxt       = in_tdata[LEN_W-1:0];
          faddr_nxt      = in_tdata[LEN_W +: ADDR_W];
          res_status_nxt = ST_OK;
          res_addr_nxt   = '0;
          cur_nxt        = head_r[IDX_W-1:0];
          prev_nxt       = LIST_END;
          scan_nxt       = '0;
          if (in_tuser == OP_ALLOC) begin
            if (head_ok) begin
              rd_en = 1'b1;
            end else begin
              res_status_nxt = ST_NO_FIT;
            end
          end
        end
      end
      S_WALK: begin
        if (fit) begin
          res_addr_nxt = r_start;
          if (exact) begin
            // unlink the spent descriptor
            valid_nxt[cur_r] = 1'b0;
            if (prev_r == LIST_END) begin
              head_nxt = r_link;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = prev_r[IDX_W-1:0];
              mem_wdata = {r_link, prev_len_r, prev_start_r};
            end
          end else begin
            mem_we    = 1'b1;
            mem_waddr = cur_r;
            mem_wdata = {r_link, rem_len, r_start + size_r[ADDR_W-1:0]};
          end
        end else if (next_ok) begin
          // advance one hop
          rd_en          = 1'b1;
          rd_addr        = r_link[IDX_W-1:0];
          prev_nxt       = LINK_W'(cur_r);
          prev_start_nxt = r_start;
          prev_len_nxt   = r_len;
          cur_nxt        = r_link[IDX_W-1:0];
        end else begin
          res_status_nxt = ST_NO_FIT;
        end
      end
      S_SCAN: begin
        if (!valid_r[scan_r]) begin
          // push the freed extent at the list head
          mem_we           = 1'b1;
          mem_waddr        = scan_r;
          mem_wdata        = {head_r, size_r, faddr_r};
          valid_nxt[scan_r] = 1'b1;
          head_nxt         = LINK_W'(scan_r);
        end else if (scan_r == LAST_SLOT) begin
          res_status_nxt = ST_NO_SLOT;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_addr_nxt   = res_addr_r;
        end
      end
      default: begin
      end
    endcase
  end

  // descriptor memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_BOOT;
      heap_start_r <= HEAP_START_RESET;
      head_r       <= LIST_END;
      valid_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        heap_start_r <= cfg_data;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r <= in_tuser;
    end
    size_r       <= size_nxt;
    faddr_r      <= faddr_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    prev_start_r <= prev_start_nxt;
    prev_len_r   <= prev_len_nxt;
    scan_r       <= scan_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // the head never points at a released descriptor while waiting for requests
  a_head_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ((head_r == LIST_END) || valid_r[head_r[IDX_W-1:0]]))
    else $error("list head points at an unused descriptor");

  // never read a slot in the same cycle it is written
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && rd_en) |-> (mem_waddr != rd_addr))
    else $error("descriptor read and write collide");

  // an exact fit releases exactly one descriptor
  a_exact_release: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && fit && exact) |=>
      ($countones(valid_r) + 1 == $past($countones(valid_r))))
    else $error("exact fit did not release one descriptor");

  // a successful free claims exactly one descriptor
  a_free_claim: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && !valid_r[scan_r]) |=>
      ($countones(valid_r) == $past($countones(valid_r)) + 1))
    else $error("free did not claim one descriptor");

  // a rebuild request only ever runs from the stored opcode
  a_rebuild_op: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REBUILD) |-> (op_r == OP_REBUILD))
    else $error("rebuild entered without a rebuild request");

endmodule
